// ===== src/bhtwm_pkg.sv =====
`timescale 1ns / 1ps

package bhtwm_pkg;

    // Operation codes of an input beat.
    localparam logic [1:0] OP_DEPOSIT  = 2'd0;
    localparam logic [1:0] OP_CLEAR    = 2'd1;
    localparam logic [1:0] OP_READOUT  = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // Status codes of a result beat.
    localparam logic [2:0] ST_MERGED  = 3'd0;
    localparam logic [2:0] ST_NEW     = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_ENTRY   = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;
    localparam logic [2:0] ST_CLEARED = 3'd5;

    localparam logic [15:0] WINDOW_RESET = 16'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_WAIT,
        S_JUDGE,
        S_WRITE,
        S_READ,
        S_READ_WAIT,
        S_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       rd_en;
        logic       write_new;
        logic       write_merge;
        logic       clear;
        logic       load_out;
        logic [2:0] out_status;
        logic       out_slot;
        logic       out_last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       bar_match;
        logic       in_window;
        logic       empty;
        logic       full;
        logic       ptr_first;
        logic       ptr_last;
    } stat_t;

endpackage

// ===== src/bhtwm_datapath.sv =====
`timescale 1ns / 1ps

module bhtwm_datapath
    import bhtwm_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int BAR_BITS    = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  logic                 ptr_dec,
    input  logic                 ptr_inc,
    input  logic                 ptr_load_top,
    input  logic                 ptr_load_zero,
    output stat_t                stat,
    input  logic [15:0]          time_window,
    input  logic [1:0]           op,
    input  logic [11:0]          bar,
    input  logic [31:0]          step_time,
    input  logic [23:0]          energy_deposit,
    input  logic [23:0]          step_length,
    input  logic [23:0]          track_number,
    input  logic signed [31:0]   particle_code,
    input  logic [31:0]          total_energy,
    input  logic signed [7:0]    particle_charge,
    output logic [2:0]           status,
    output logic [5:0]           hit_index,
    output logic [11:0]          hit_bar,
    output logic [31:0]          hit_time,
    output logic [31:0]          energy_sum,
    output logic [31:0]          path_sum,
    output logic [23:0]          hit_track,
    output logic signed [31:0]   hit_particle,
    output logic [31:0]          hit_total_energy,
    output logic signed [7:0]    hit_charge,
    output logic                 last
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Captured input beat.
    logic [1:0]          op_reg;
    logic [BAR_BITS-1:0] bar_reg;
    logic [31:0]         time_reg;
    logic [23:0]         edep_reg;
    logic [23:0]         len_reg;
    logic [23:0]         track_reg;
    logic [31:0]         part_reg;
    logic [31:0]         tot_reg;
    logic [7:0]          chg_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] ptr_next;

    // Hit table memories.
    logic [BAR_BITS-1:0] bar_mem   [TABLE_DEPTH];
    logic [31:0]         time_mem  [TABLE_DEPTH];
    logic [31:0]         en_mem    [TABLE_DEPTH];
    logic [31:0]         path_mem  [TABLE_DEPTH];
    logic [23:0]         track_mem [TABLE_DEPTH];
    logic [31:0]         part_mem  [TABLE_DEPTH];
    logic [31:0]         tot_mem   [TABLE_DEPTH];
    logic [7:0]          chg_mem   [TABLE_DEPTH];

    logic [BAR_BITS-1:0] rd_bar;
    logic [31:0]         rd_time;
    logic [31:0]         rd_en;
    logic [31:0]         rd_path;
    logic [23:0]         rd_track;
    logic [31:0]         rd_part;
    logic [31:0]         rd_tot;
    logic [7:0]          rd_chg;

    // Input capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            bar_reg   <= BAR_BITS'(bar);
            time_reg  <= step_time;
            edep_reg  <= energy_deposit;
            len_reg   <= step_length;
            track_reg <= track_number;
            part_reg  <= particle_code;
            tot_reg   <= total_energy;
            chg_reg   <= particle_charge;
        end
    end

    // Hit count and scan pointer.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
            count_next = '0;
        else if (cmd.write_new)
            count_next = count_reg + CW'(1);
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (ptr_load_top)
            ptr_next = AW'(count_reg - CW'(1));
        else if (ptr_load_zero)
            ptr_next = '0;
        else if (ptr_dec)
            ptr_next = ptr_reg - AW'(1);
        else if (ptr_inc)
            ptr_next = ptr_reg + AW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
        end
    end

    // Saturating sums: slot under the pointer, or zero for a new slot.
    logic [32:0] en_add;
    logic [32:0] path_add;
    logic [31:0] en_base;
    logic [31:0] path_base;
    logic [31:0] en_new;
    logic [31:0] path_new;
    logic [AW-1:0] wr_addr;

    assign en_base   = cmd.write_new ? 32'd0 : rd_en;
    assign path_base = cmd.write_new ? 32'd0 : rd_path;
    assign en_add    = {1'b0, en_base} + {9'd0, edep_reg};
    assign path_add  = {1'b0, path_base} + {9'd0, len_reg};
    assign en_new    = en_add[32] ? 32'hFFFF_FFFF : en_add[31:0];
    assign path_new  = path_add[32] ? 32'hFFFF_FFFF : path_add[31:0];
    assign wr_addr   = cmd.write_new ? AW'(count_reg) : ptr_reg;

    // Table write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.write_new)
        begin
            bar_mem[wr_addr]   <= bar_reg;
            time_mem[wr_addr]  <= time_reg;
            track_mem[wr_addr] <= track_reg;
            part_mem[wr_addr]  <= part_reg;
            tot_mem[wr_addr]   <= tot_reg;
            chg_mem[wr_addr]   <= chg_reg;
        end
        if (cmd.write_new || cmd.write_merge)
        begin
            en_mem[wr_addr]   <= en_new;
            path_mem[wr_addr] <= path_new;
        end
        if (cmd.rd_en)
        begin
            rd_bar   <= bar_mem[ptr_reg];
            rd_time  <= time_mem[ptr_reg];
            rd_en    <= en_mem[ptr_reg];
            rd_path  <= path_mem[ptr_reg];
            rd_track <= track_mem[ptr_reg];
            rd_part  <= part_mem[ptr_reg];
            rd_tot   <= tot_mem[ptr_reg];
            rd_chg   <= chg_mem[ptr_reg];
        end
    end

    // Window test against the item time truncated to whole ns.
    logic [31:0] tq;
    logic [31:0] gap;
    logic [20:0] win16;

    assign tq    = {time_reg[31:4], 4'd0};
    assign gap   = (rd_time >= tq) ? (rd_time - tq) : (tq - rd_time);
    assign win16 = {1'b0, time_window, 4'd0};

    always_comb
    begin
        stat.op        = op_reg;
        stat.bar_match = (rd_bar == bar_reg);
        stat.in_window = (gap <= {11'd0, win16});
        stat.empty     = (count_reg == '0);
        stat.full      = (count_reg >= CW'(TABLE_DEPTH));
        stat.ptr_first = (ptr_reg == '0);
        stat.ptr_last  = (CW'(ptr_reg) + CW'(1) == count_reg);
    end

    // Output register; slot fields come from the table or the write values.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status <= cmd.out_status;
            last   <= cmd.out_last;
            if (cmd.out_slot)
            begin
                hit_index        <= 6'(wr_addr);
                hit_bar          <= 12'(rd_bar);
                hit_time         <= rd_time;
                energy_sum       <= rd_en;
                path_sum         <= rd_path;
                hit_track        <= rd_track;
                hit_particle     <= rd_part;
                hit_total_energy <= rd_tot;
                hit_charge       <= rd_chg;
                if (cmd.write_new)
                begin
                    hit_bar          <= 12'(bar_reg);
                    hit_time         <= time_reg;
                    hit_track        <= track_reg;
                    hit_particle     <= part_reg;
                    hit_total_energy <= tot_reg;
                    hit_charge       <= chg_reg;
                end
                if (cmd.write_new || cmd.write_merge)
                begin
                    energy_sum <= en_new;
                    path_sum   <= path_new;
                end
            end
            else
            begin
                hit_index        <= '0;
                hit_bar          <= (cmd.out_status == ST_FULL) ? 12'(bar_reg) : 12'd0;
                hit_time         <= '0;
                energy_sum       <= '0;
                path_sum         <= '0;
                hit_track        <= '0;
                hit_particle     <= '0;
                hit_total_energy <= '0;
                hit_charge       <= '0;
            end
        end
    end

endmodule

// ===== src/bhtwm_ctrl.sv =====
`timescale 1ns / 1ps

module bhtwm_ctrl
    import bhtwm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic [1:0] op,
    output logic  out_valid,
    input  logic  out_stall,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  ptr_dec,
    output logic  ptr_inc,
    output logic  ptr_load_top,
    output logic  ptr_load_zero,
    output logic  busy
);

    state_t state_reg;
    state_t state_next;
    logic   valid_reg;
    logic   valid_next;
    state_t after_reg;
    state_t after_next;

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            after_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            after_reg <= after_next;
        end
    end

    logic out_free;
    assign out_free  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign in_stall  = (state_reg != S_IDLE);
    assign busy      = (state_reg != S_IDLE) || valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        after_next    = after_reg;
        valid_next    = valid_reg && out_stall;
        cmd           = '0;
        ptr_dec       = 1'b0;
        ptr_inc       = 1'b0;
        ptr_load_top  = 1'b0;
        ptr_load_zero = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (op)
                        OP_DEPOSIT:
                        begin
                            ptr_load_top = 1'b1;
                            state_next   = S_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            cmd.clear      = 1'b1;
                            cmd.out_status = ST_CLEARED;
                            cmd.out_last   = 1'b1;
                            after_next     = S_IDLE;
                            state_next     = S_OUT;
                        end
                        OP_READOUT:
                        begin
                            ptr_load_zero = 1'b1;
                            state_next    = S_READ;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (stat.empty)
                    state_next = S_WRITE;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT:
            begin
                state_next = S_JUDGE;
            end
            S_JUDGE:
            begin
                if (stat.bar_match)
                begin
                    if (stat.in_window && out_free)
                    begin
                        cmd.write_merge = 1'b1;
                        cmd.load_out    = 1'b1;
                        cmd.out_slot    = 1'b1;
                        cmd.out_status  = ST_MERGED;
                        cmd.out_last    = 1'b1;
                        valid_next      = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else if (!stat.in_window)
                        state_next = S_WRITE;
                end
                else if (stat.ptr_first)
                    state_next = S_WRITE;
                else
                begin
                    ptr_dec    = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = S_IDLE;
                    if (stat.full)
                        cmd.out_status = ST_FULL;
                    else
                    begin
                        cmd.write_new  = 1'b1;
                        cmd.out_slot   = 1'b1;
                        cmd.out_status = ST_NEW;
                    end
                end
            end
            S_READ:
            begin
                if (stat.empty)
                begin
                    cmd.out_status = ST_EMPTY;
                    cmd.out_last   = 1'b1;
                    after_next     = S_IDLE;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_READ_WAIT;
                end
            end
            S_READ_WAIT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_slot   = 1'b1;
                    cmd.out_status = ST_ENTRY;
                    cmd.out_last   = stat.ptr_last;
                    valid_next     = 1'b1;
                    if (stat.ptr_last)
                        state_next = S_IDLE;
                    else
                    begin
                        ptr_inc    = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_status = (stat.op == OP_CLEAR) ? ST_CLEARED : ST_EMPTY;
                    cmd.out_last   = 1'b1;
                    valid_next     = 1'b1;
                    state_next     = after_reg;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ===== src/bar_hit_time_window_merger.sv =====
`timescale 1ns / 1ps

// Bar hit time-window merger.
// Input channel (in_valid/in_stall) carries one item per beat: op selects a
// deposit, a table clear or a readout. Results leave on the output channel
// (out_valid/out_stall), one beat each, with last set on the final beat that
// an item causes. time_window is written through cfg_valid/cfg_ready while
// the block is idle; cfg_ready is low while an item is in flight.
// A deposit scans the table from the newest slot down for its bar; each
// slot examined passes S_SCAN, S_SCAN_WAIT and S_JUDGE through the
// registered table read port. A merge is written in S_JUDGE; opening a hit
// or dropping the item (table full) is done in S_WRITE. A readout passes
// S_READ and S_READ_WAIT for each stored hit (S_READ and S_OUT for an
// empty table); a clear goes from S_IDLE to S_OUT.
// One item is in work at a time; in_stall is high until its last result is
// loaded into the output register.
// Reset empties the table and sets time_window to 10 ns; table contents are
// not cleared. While out_stall is high the output register holds its beat
// and the controller waits before loading the next one.
module bar_hit_time_window_merger
    import bhtwm_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int BAR_BITS    = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           op,
    input  logic [11:0]          bar,
    input  logic [31:0]          step_time,
    input  logic [23:0]          energy_deposit,
    input  logic [23:0]          step_length,
    input  logic [23:0]          track_number,
    input  logic signed [31:0]   particle_code,
    input  logic [31:0]          total_energy,
    input  logic signed [7:0]    particle_charge,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [5:0]           hit_index,
    output logic [11:0]          hit_bar,
    output logic [31:0]          hit_time,
    output logic [31:0]          energy_sum,
    output logic [31:0]          path_sum,
    output logic [23:0]          hit_track,
    output logic signed [31:0]   hit_particle,
    output logic [31:0]          hit_total_energy,
    output logic signed [7:0]    hit_charge,
    output logic                 last
);

    cmd_t  cmd;
    stat_t stat;
    logic  ptr_dec;
    logic  ptr_inc;
    logic  ptr_load_top;
    logic  ptr_load_zero;
    logic  busy;
    logic [15:0] window_reg;

    // Window register.
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= WINDOW_RESET;
        else if (cfg_valid && cfg_ready)
            window_reg <= cfg_data;
    end

    bhtwm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .stat          (stat),
        .cmd           (cmd),
        .ptr_dec       (ptr_dec),
        .ptr_inc       (ptr_inc),
        .ptr_load_top  (ptr_load_top),
        .ptr_load_zero (ptr_load_zero),
        .busy          (busy)
    );

    bhtwm_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .BAR_BITS    (BAR_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .ptr_dec          (ptr_dec),
        .ptr_inc          (ptr_inc),
        .ptr_load_top     (ptr_load_top),
        .ptr_load_zero    (ptr_load_zero),
        .stat             (stat),
        .time_window      (window_reg),
        .op               (op),
        .bar              (bar),
        .step_time        (step_time),
        .energy_deposit   (energy_deposit),
        .step_length      (step_length),
        .track_number     (track_number),
        .particle_code    (particle_code),
        .total_energy     (total_energy),
        .particle_charge  (particle_charge),
        .status           (status),
        .hit_index        (hit_index),
        .hit_bar          (hit_bar),
        .hit_time         (hit_time),
        .energy_sum       (energy_sum),
        .path_sum         (path_sum),
        .hit_track        (hit_track),
        .hit_particle     (hit_particle),
        .hit_total_energy (hit_total_energy),
        .hit_charge       (hit_charge),
        .last             (last)
    );

endmodule
